>>> hw/rtl/rdsc_pkg.sv
// Package for the radix digit string converter.
// Holds the field widths, status and state codes, the queue word type and
// the digit-to-ASCII function. It depends on nothing.
package rdsc_pkg;

   localparam int WHOLE_W    = 31;
   localparam int FRAC_W     = 32;
   localparam int RADIX_W    = 5;
   localparam int BASE_W     = 4;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 7;
   localparam int STATUS_W   = 2;

   localparam int WHOLE_DIGITS_MAX_DEF    = 31;
   localparam int FRACTION_DIGITS_MAX_DEF = 10;

   localparam int QUEUE_DEPTH = 2;

   localparam int DIV_BITS  = 8;
   localparam int DIV_STEPS = (WHOLE_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_W     = DIV_STEPS * DIV_BITS;

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_LIMIT = RADIX_W'(16);

   localparam logic [FRAC_W-1:0] FRAC_STOP_LEVEL = FRAC_W'(42);

   localparam logic [CHAR_W-1:0] CHAR_COMMA = CHAR_W'(8'h2C);
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
   localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(8'h41);
   localparam logic [CHAR_W-1:0] CHAR_NONE  = CHAR_W'(0);

   localparam logic [STATUS_W-1:0] STATUS_OK        = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_BASE_LOW  = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_BASE_HIGH = STATUS_W'(2);

   typedef struct packed {
      logic [WHOLE_W-1:0]  whole_part;
      logic [FRAC_W-1:0]   fraction_part;
      logic [BASE_W-1:0]   base;
      logic [STATUS_W-1:0] status;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERROR,
      ST_DIVIDE,
      ST_WAIT,
      ST_WHOLE,
      ST_COMMA,
      ST_FRACTION
   } state_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DIGIT_W'(10)) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/rdsc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rdsc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/rdsc_front.sv
// Front end: holds the radix register, accepts request words and tags
// each one with its base and status. Depends on rdsc_pkg.
module rdsc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rdsc_pkg::RADIX_W-1:0]   csr_radix,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rdsc_pkg::WHOLE_W-1:0]   req_whole_part,
   input  logic [rdsc_pkg::FRAC_W-1:0]    req_fraction_part,
   input  logic                           queue_full,
   output logic                           push,
   output rdsc_pkg::job_type              push_job
);
   import rdsc_pkg::*;

   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_in;

   always_comb begin
      radix_in = radix_ff;
      if (csr_valid) begin
         radix_in = csr_radix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_job.whole_part    = req_whole_part;
      push_job.fraction_part = req_fraction_part;
      push_job.base          = radix_ff[BASE_W-1:0];
      if (radix_ff < RADIX_MIN) begin
         push_job.status = STATUS_BASE_LOW;
      end else if (radix_ff >= RADIX_LIMIT) begin
         push_job.status = STATUS_BASE_HIGH;
      end else begin
         push_job.status = STATUS_OK;
      end
   end

endmodule

>>> hw/rtl/rdsc_queue.sv
// Short queue of tagged jobs between the front end and the back end.
// Depends on rdsc_pkg.
module rdsc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rdsc_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output rdsc_pkg::job_type head
);
   import rdsc_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            do_push;
   logic            do_pop;

   assign full    = (count_ff == CW'(QUEUE_DEPTH));
   assign empty   = (count_ff == CW'(0));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/rdsc_back.sv
// Back end: divides out the whole-part digits into the digit RAM, then emits
// them reversed, the comma and the fraction digits, or one error word for a
// bad base, through the response register. Depends on rdsc_pkg and rdsc_ram.
module rdsc_back #(
   parameter int WHOLE_DIGITS_MAX    = rdsc_pkg::WHOLE_DIGITS_MAX_DEF,
   parameter int FRACTION_DIGITS_MAX = rdsc_pkg::FRACTION_DIGITS_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_empty,
   input  rdsc_pkg::job_type             head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rdsc_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic                          rsp_last,
   output logic [rdsc_pkg::STATUS_W-1:0] rsp_status
);
   import rdsc_pkg::*;

   localparam int AW  = $clog2(WHOLE_DIGITS_MAX);
   localparam int CW  = $clog2(WHOLE_DIGITS_MAX + 1);
   localparam int IW  = $clog2(FRACTION_DIGITS_MAX + 1);
   localparam int SW  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int PRW = FRAC_W + BASE_W;

   state_type           state_ff;
   state_type           state_in;
   logic [BASE_W-1:0]   base_ff;
   logic [BASE_W-1:0]   base_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [DIV_W-1:0]    dvd_ff;
   logic [DIV_W-1:0]    dvd_in;
   logic [DIV_W-1:0]    quo_ff;
   logic [DIV_W-1:0]    quo_in;
   logic [DIGIT_W-1:0]  rem_ff;
   logic [DIGIT_W-1:0]  rem_in;
   logic [SW-1:0]       step_ff;
   logic [SW-1:0]       step_in;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [AW-1:0]       idx_ff;
   logic [AW-1:0]       idx_in;
   logic [FRAC_W-1:0]   frac_ff;
   logic [FRAC_W-1:0]   frac_in;
   logic [IW-1:0]       iter_ff;
   logic [IW-1:0]       iter_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [CHAR_W-1:0]   char_ff;
   logic [CHAR_W-1:0]   char_in;
   logic                last_ff;
   logic                last_in;
   logic [STATUS_W-1:0] rstat_ff;
   logic [STATUS_W-1:0] rstat_in;

   logic [DIGIT_W:0]    rem_v;
   logic [DIV_W-1:0]    dvd_v;
   logic [DIV_W-1:0]    quo_v;
   logic [PRW-1:0]      prod;
   logic                frac_done;
   logic                out_free;
   logic                ram_we;
   logic [DIGIT_W-1:0]  ram_rdata;

   rdsc_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (WHOLE_DIGITS_MAX)
   ) u_digits (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (rem_v[DIGIT_W-1:0]),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   // Restoring division, DIV_BITS quotient bits per cycle.
   always_comb begin
      rem_v = {1'b0, rem_ff};
      dvd_v = dvd_ff;
      quo_v = quo_ff;
      for (int j = 0; j < DIV_BITS; j++) begin
         rem_v = {rem_v[DIGIT_W-1:0], dvd_v[DIV_W-1]};
         dvd_v = {dvd_v[DIV_W-2:0], 1'b0};
         if (rem_v >= {1'b0, base_ff}) begin
            rem_v = rem_v - {1'b0, base_ff};
            quo_v = {quo_v[DIV_W-2:0], 1'b1};
         end else begin
            quo_v = {quo_v[DIV_W-2:0], 1'b0};
         end
      end
   end

   assign prod      = {{BASE_W{1'b0}}, frac_ff} * {{FRAC_W{1'b0}}, base_ff};
   assign frac_done = (prod[FRAC_W-1:0] <= FRAC_STOP_LEVEL)
                      || (iter_ff == IW'(FRACTION_DIGITS_MAX - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      status_in    = status_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in      = char_ff;
      last_in      = last_ff;
      rstat_in     = rstat_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop       = 1'b1;
               base_in   = head.base;
               status_in = head.status;
               dvd_in    = {{(DIV_W - WHOLE_W){1'b0}}, head.whole_part};
               rem_in    = '0;
               step_in   = '0;
               count_in  = '0;
               frac_in   = head.fraction_part;
               iter_in   = '0;
               state_in  = (head.status == STATUS_OK) ? ST_DIVIDE : ST_ERROR;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CHAR_NONE;
               last_in      = 1'b1;
               rstat_in     = status_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            dvd_in  = dvd_v;
            quo_in  = quo_v;
            rem_in  = rem_v[DIGIT_W-1:0];
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(DIV_STEPS - 1)) begin
               ram_we   = 1'b1;
               count_in = count_ff + CW'(1);
               dvd_in   = quo_v;
               rem_in   = '0;
               step_in  = '0;
               if ((quo_v == '0) || (count_ff == CW'(WHOLE_DIGITS_MAX - 1))) begin
                  idx_in   = count_ff[AW-1:0];
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            state_in = ST_WHOLE;
         end
         ST_WHOLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = digit_to_ascii(ram_rdata);
               last_in      = 1'b0;
               rstat_in     = STATUS_OK;
               if (idx_ff == '0) begin
                  state_in = ST_COMMA;
               end else begin
                  idx_in   = idx_ff - AW'(1);
                  state_in = ST_WAIT;
               end
            end
         end
         ST_COMMA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CHAR_COMMA;
               last_in      = 1'b0;
               rstat_in     = STATUS_OK;
               state_in     = ST_FRACTION;
            end
         end
         ST_FRACTION: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = digit_to_ascii(prod[PRW-1:FRAC_W]);
               last_in      = frac_done;
               rstat_in     = STATUS_OK;
               frac_in      = prod[FRAC_W-1:0];
               iter_in      = iter_ff + IW'(1);
               if (frac_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         iter_ff      <= '0;
         step_ff      <= '0;
         idx_ff       <= '0;
         dvd_ff       <= '0;
         frac_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         iter_ff      <= iter_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         dvd_ff       <= dvd_in;
         frac_ff      <= frac_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      status_ff <= status_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      rstat_ff  <= rstat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_status    = rstat_ff;

endmodule

>>> hw/rtl/radix_digit_string_converter.sv
// Radix digit string converter, top level. The division unit divides out each
// whole digit (8 quotient bits per cycle) into the digit RAM; each whole digit
// is then read back through the registered RAM read port (state ST_WAIT) before
// it is emitted, followed by the comma and the fraction digits. The back end
// converts one word at a time; the two-entry queue accepts further words meanwhile.
// Reset is synchronous and active high; the radix register returns to 10.
// Depends on rdsc_pkg, rdsc_front, rdsc_queue and rdsc_back.
module radix_digit_string_converter #(
   parameter int WHOLE_DIGITS_MAX    = rdsc_pkg::WHOLE_DIGITS_MAX_DEF,
   parameter int FRACTION_DIGITS_MAX = rdsc_pkg::FRACTION_DIGITS_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rdsc_pkg::RADIX_W-1:0]  csr_radix,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rdsc_pkg::WHOLE_W-1:0]  req_whole_part,
   input  logic [rdsc_pkg::FRAC_W-1:0]   req_fraction_part,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rdsc_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic                          rsp_last,
   output logic [rdsc_pkg::STATUS_W-1:0] rsp_status
);
   import rdsc_pkg::*;

   job_type push_job;
   job_type head;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;

   rdsc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_radix         (csr_radix),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_whole_part    (req_whole_part),
      .req_fraction_part (req_fraction_part),
      .queue_full        (queue_full),
      .push              (push),
      .push_job          (push_job)
   );

   rdsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head     (head)
   );

   rdsc_back #(
      .WHOLE_DIGITS_MAX    (WHOLE_DIGITS_MAX),
      .FRACTION_DIGITS_MAX (FRACTION_DIGITS_MAX)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status)
   );

endmodule
